// ----- rtl/conv2d_valid_window_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the conv2d valid window unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_WINDOW_UNIT_ASSERT_SVH
`define CONV2D_VALID_WINDOW_UNIT_ASSERT_SVH

// An expression that must hold at every clock edge out of reset.
`define CVW_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// An antecedent that implies a consequent at the next clock edge.
`define CVW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cvw_pkg.sv -----
// ----------------------------------------------------------------------------
// cvw_pkg
// Shared constants, codes and the queue entry type of the window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cvw_pkg;

	localparam int KSIZE_DEF      = 3;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int FIFO_DEPTH     = 4;

	localparam int PIX_W          = 8;
	localparam int COEF_W         = 16;
	localparam int CIDX_W         = 4;
	localparam int SUM_OUT_W      = 28;
	localparam int ROW_OUT_W      = 16;
	localparam int COL_OUT_W      = 10;
	localparam int COL_ADDR_W     = 12;
	localparam int LINE_WIDTH_W   = 11;
	localparam int FRAME_HEIGHT_W = 16;

	localparam int S_TDATA_W      = 32;
	localparam int M_TDATA_W      = 56;

	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	localparam logic MODE_COEF  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct packed {
		logic                        kind;
		logic [CIDX_W-1:0]           coef_index;
		logic signed [COEF_W-1:0]    coef_value;
		logic [PIX_W-1:0]            pixel;
		logic [COL_ADDR_W-1:0]       col;
		logic                        produce;
		logic                        last;
		logic [ROW_OUT_W-1:0]        out_row;
		logic [COL_OUT_W-1:0]        out_col;
	} item_t;

endpackage

`default_nettype wire

// ----- rtl/cvw_fifo.sv -----
// ----------------------------------------------------------------------------
// cvw_fifo
// Short register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cvw_fifo #(
	parameter int DEPTH = cvw_pkg::FIFO_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cvw_pkg::item_t push_data,
	output logic               full,
	input  wire logic          pop,
	output cvw_pkg::item_t     pop_data,
	output logic               empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	cvw_pkg::item_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign full     = (cnt_q == CNTW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`include "conv2d_valid_window_unit_assert.svh"

	`CVW_ASSERT_ALWAYS(a_no_overflow, !(push && full), "Queue written while full.")
	`CVW_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "Queue read while empty.")

endmodule

`default_nettype wire

// ----- rtl/cvw_front.sv -----
// ----------------------------------------------------------------------------
// cvw_front
// Accepts stream items, holds the configuration and the raster counters,
// and tags each item with its column, result flag and output position.
// ----------------------------------------------------------------------------
`default_nettype none

module cvw_front #(
	parameter int KSIZE     = cvw_pkg::KSIZE_DEF,
	parameter int MAX_WIDTH = cvw_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [cvw_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic                            s_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cvw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cvw_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                 push,
	output cvw_pkg::item_t                       push_data,
	input  wire logic                            full
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > cvw_pkg::LINE_WIDTH_W + 1) ? CW + 1
		: cvw_pkg::LINE_WIDTH_W + 1;
	localparam int RW = cvw_pkg::FRAME_HEIGHT_W;

	logic [cvw_pkg::LINE_WIDTH_W-1:0]   line_width_q;
	logic [cvw_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [CW-1:0]                      col_q;
	logic [RW-1:0]                      row_q;

	logic [CMPW-1:0] col_inc;
	logic [RW:0]     row_inc;
	logic            col_end;
	logic            row_end;
	logic            accept;

	assign s_tready  = !full;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign push      = accept;

	assign col_inc = CMPW'(col_q) + CMPW'(1);
	assign row_inc = {1'b0, row_q} + (RW + 1)'(1);
	assign col_end = (col_inc >= CMPW'(line_width_q)) || (col_inc >= CMPW'(MAX_WIDTH));
	assign row_end = (row_inc >= {1'b0, frame_height_q});

	always_comb begin
		push_data            = '0;
		push_data.kind       = s_tuser;
		push_data.coef_index = s_tdata[3:0];
		push_data.coef_value = s_tdata[19:4];
		push_data.pixel      = s_tdata[27:20];
		push_data.col        = cvw_pkg::COL_ADDR_W'(col_q);
		push_data.produce    = (int'(col_q) >= KSIZE - 1) && (int'(row_q) >= KSIZE - 1);
		push_data.last       = col_end && row_end;
		push_data.out_row    = row_q - RW'(KSIZE - 1);
		push_data.out_col    = cvw_pkg::COL_OUT_W'(col_q - CW'(KSIZE - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= cvw_pkg::LINE_WIDTH_RST;
			frame_height_q <= cvw_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cvw_pkg::REG_LINE_WIDTH: begin
					line_width_q <= cfg_data[cvw_pkg::LINE_WIDTH_W-1:0];
				end
				cvw_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[cvw_pkg::FRAME_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && s_tuser == cvw_pkg::MODE_PIXEL) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

`include "conv2d_valid_window_unit_assert.svh"

	`CVW_ASSERT_ALWAYS(a_col_range, int'(col_q) < MAX_WIDTH, "Column counter out of range.")

endmodule

`default_nettype wire

// ----- rtl/cvw_back.sv -----
// ----------------------------------------------------------------------------
// cvw_back
// Line memory, window registers, coefficient store, product lanes and a
// two-level registered adder tree, all advancing together on one enable.
// ----------------------------------------------------------------------------
`default_nettype none

module cvw_back #(
	parameter int KSIZE     = cvw_pkg::KSIZE_DEF,
	parameter int MAX_WIDTH = cvw_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire cvw_pkg::item_t                        pop_data,
	input  wire logic                                  empty,
	output logic                                       pop,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic signed [cvw_pkg::SUM_OUT_W-1:0]       sum,
	output logic [cvw_pkg::ROW_OUT_W-1:0]              out_row,
	output logic [cvw_pkg::COL_OUT_W-1:0]              out_col,
	output logic                                       frame_last
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int KTAPS  = KSIZE * KSIZE;
	localparam int LROWS  = KSIZE - 1;
	localparam int PW     = cvw_pkg::PIX_W;
	localparam int LW     = LROWS * PW;
	localparam int PROD_W = PW + 1 + cvw_pkg::COEF_W;
	localparam int ROW_W  = PROD_W + $clog2(KSIZE);
	localparam int ACC_W  = ROW_W + $clog2(KSIZE);
	localparam int SUM_W  = (ACC_W > cvw_pkg::SUM_OUT_W) ? ACC_W : cvw_pkg::SUM_OUT_W;

	logic en;

	logic [LW-1:0]                   line_mem [MAX_WIDTH];
	logic [LW-1:0]                   rdata_s1;
	cvw_pkg::item_t                  item_s1;
	logic                            valid_s1;
	logic                            pix_s1;
	logic                            coef_s1;

	logic                            fwd_valid_q;
	logic [CW-1:0]                   fwd_addr_q;
	logic [LW-1:0]                   fwd_data_q;

	logic [PW-1:0]                   win_q [KTAPS];
	logic signed [cvw_pkg::COEF_W-1:0] coef_q [KTAPS];

	logic [LW-1:0]                   old_word;
	logic [LW-1:0]                   new_word;
	logic [PW-1:0]                   column [KSIZE];
	logic [PW-1:0]                   win_c [KTAPS];
	logic signed [PROD_W-1:0]        prod_c [KTAPS];

	logic                            valid_s2;
	logic signed [PROD_W-1:0]        prod_s2 [KTAPS];
	logic [cvw_pkg::ROW_OUT_W-1:0]   row_s2;
	logic [cvw_pkg::COL_OUT_W-1:0]   col_s2;
	logic                            last_s2;

	logic                            valid_s3;
	logic signed [ROW_W-1:0]         rsum_c [KSIZE];
	logic signed [ROW_W-1:0]         rsum_s3 [KSIZE];
	logic [cvw_pkg::ROW_OUT_W-1:0]   row_s3;
	logic [cvw_pkg::COL_OUT_W-1:0]   col_s3;
	logic                            last_s3;
	logic signed [SUM_W-1:0]         total_c;

	logic                            out_valid_q;
	logic signed [cvw_pkg::SUM_OUT_W-1:0] sum_q;
	logic [cvw_pkg::ROW_OUT_W-1:0]   out_row_q;
	logic [cvw_pkg::COL_OUT_W-1:0]   out_col_q;
	logic                            last_q;

	assign en      = !out_valid_q || m_tready;
	assign pop     = en && !empty;
	assign pix_s1  = valid_s1 && (item_s1.kind == cvw_pkg::MODE_PIXEL);
	assign coef_s1 = valid_s1 && (item_s1.kind == cvw_pkg::MODE_COEF);

	always_comb begin
		if (fwd_valid_q && fwd_addr_q == item_s1.col[CW-1:0]) begin
			old_word = fwd_data_q;
		end else begin
			old_word = rdata_s1;
		end
		for (int i = 0; i < LROWS; i++) begin
			column[i] = old_word[(LROWS - 1 - i) * PW +: PW];
		end
		column[KSIZE-1] = item_s1.pixel;
		new_word = {old_word[LW-PW-1:0], item_s1.pixel};
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE - 1; j++) begin
				win_c[i * KSIZE + j] = win_q[i * KSIZE + j + 1];
			end
			win_c[i * KSIZE + KSIZE - 1] = column[i];
		end
	end

	for (genvar t = 0; t < KTAPS; t++) begin : g_lane
		assign prod_c[t] = $signed({1'b0, win_c[t]}) * coef_q[t];
	end

	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			rsum_c[r] = '0;
			for (int j = 0; j < KSIZE; j++) begin
				rsum_c[r] = rsum_c[r] + ROW_W'(prod_s2[r * KSIZE + j]);
			end
		end
	end

	always_comb begin
		total_c = '0;
		for (int r = 0; r < KSIZE; r++) begin
			total_c = total_c + SUM_W'(rsum_s3[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s1 <= line_mem[pop_data.col[CW-1:0]];
			if (pix_s1) begin
				line_mem[item_s1.col[CW-1:0]] <= new_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
			for (int t = 0; t < KTAPS; t++) begin
				win_q[t] <= '0;
			end
		end else if (en) begin
			valid_s1    <= !empty;
			valid_s2    <= pix_s1 && item_s1.produce;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (pix_s1) begin
				fwd_valid_q <= 1'b1;
				for (int t = 0; t < KTAPS; t++) begin
					win_q[t] <= win_c[t];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= pop_data;
			if (pix_s1) begin
				fwd_addr_q <= item_s1.col[CW-1:0];
				fwd_data_q <= new_word;
			end
			if (coef_s1) begin
				for (int t = 0; t < KTAPS; t++) begin
					if (int'(item_s1.coef_index) == t) begin
						coef_q[t] <= item_s1.coef_value;
					end
				end
			end
			for (int t = 0; t < KTAPS; t++) begin
				prod_s2[t] <= prod_c[t];
			end
			row_s2  <= item_s1.out_row;
			col_s2  <= item_s1.out_col;
			last_s2 <= item_s1.last;
			for (int r = 0; r < KSIZE; r++) begin
				rsum_s3[r] <= rsum_c[r];
			end
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			last_s3   <= last_s2;
			sum_q     <= total_c[cvw_pkg::SUM_OUT_W-1:0];
			out_row_q <= row_s3;
			out_col_q <= col_s3;
			last_q    <= last_s3;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign sum        = sum_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = last_q;

`include "conv2d_valid_window_unit_assert.svh"

	`CVW_ASSERT_NEXT(a_s2_hold, valid_s2 && !en, valid_s2, "Product stage lost during stall.")
	`CVW_ASSERT_NEXT(a_pop_fills_s1, pop, valid_s1, "Popped item did not reach stage one.")

endmodule

`default_nettype wire

// ----- rtl/conv2d_valid_window_unit.sv -----
// ----------------------------------------------------------------------------
// conv2d_valid_window_unit
// Streaming valid-region 2D correlation over raster pixels with a loadable
// KSIZE by KSIZE kernel of signed Q2.14 coefficients.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Accepted when            Carries
//   s_*       in         s_tvalid && s_tready     coefficient load or pixel
//   m_*       out        m_tvalid && m_tready     sum, output row and column
//   cfg_*     in         cfg_valid && cfg_ready   line_width, frame_height
//
// One item is accepted per clock while the queue is not full; a result
// passes in order through the queue, the registered line read, the product
// lanes, the row sums and the final sum register.
// The line memory has one read and one write port, with the last write
// forwarded to a read of the same column that was issued alongside it.
// A four-entry queue keeps the input open while the output stalls.
// Reset clears counters, window and control state; line and coefficient
// storage need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_valid_window_unit #(
	parameter int KSIZE     = cvw_pkg::KSIZE_DEF,
	parameter int MAX_WIDTH = cvw_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// coef_index[3:0], coef_value[19:4], pixel[27:20], zero fill
	input  wire logic [cvw_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode[0]
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// sum[27:0], out_row[43:28], out_col[53:44], zero fill
	output logic [cvw_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic                                 m_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cvw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cvw_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int M_PAD = cvw_pkg::M_TDATA_W - cvw_pkg::SUM_OUT_W
		- cvw_pkg::ROW_OUT_W - cvw_pkg::COL_OUT_W;

	cvw_pkg::item_t push_data;
	cvw_pkg::item_t pop_data;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	logic signed [cvw_pkg::SUM_OUT_W-1:0] sum;
	logic [cvw_pkg::ROW_OUT_W-1:0]        out_row;
	logic [cvw_pkg::COL_OUT_W-1:0]        out_col;

	cvw_front #(
		.KSIZE     (KSIZE),
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	cvw_fifo #(
		.DEPTH (cvw_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	cvw_back #(
		.KSIZE     (KSIZE),
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_data   (pop_data),
		.empty      (empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.sum        (sum),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (m_tlast)
	);

	assign m_tdata = {M_PAD'(0), out_col, out_row, sum};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for conv2d_valid_window_unit
// Drives coefficient loads and raster pixels through the stream input and
// keeps its own model of the line buffers, window, kernel and counters.
// Every output transaction is checked field by field against the oldest
// predicted window sum. A directed table opens the run. Small frames with
// random content, random stalls on both sides and register changes between
// frames follow. A frame with no stalls closes the run.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KS         = cvw_pkg::KSIZE_DEF;
	localparam int KT         = KS * KS;
	localparam int MAXW       = cvw_pkg::MAX_WIDTH_DEF;
	localparam int SETTLE     = 24;
	localparam int LIMIT      = 1_000_000;
	localparam int RAND_TOTAL = 760;
	localparam int PAUSE_AT   = 400;

	typedef struct packed {
		logic                              mode;
		logic [cvw_pkg::CIDX_W-1:0]        coef_index;
		logic signed [cvw_pkg::COEF_W-1:0] coef_value;
		logic [cvw_pkg::PIX_W-1:0]         pixel;
	} pix_item_t;

	typedef struct packed {
		logic signed [cvw_pkg::SUM_OUT_W-1:0] sum;
		logic [cvw_pkg::ROW_OUT_W-1:0]        row;
		logic [cvw_pkg::COL_OUT_W-1:0]        col;
		logic                                 last;
	} window_sum_t;

	typedef struct {
		pix_item_t   it;
		bit          typed;
		window_sum_t want;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	// coef_index[3:0], coef_value[19:4], pixel[27:20], zero fill
	logic [cvw_pkg::S_TDATA_W-1:0]  s_tdata;
	// mode[0]
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	// sum[27:0], out_row[43:28], out_col[53:44], zero fill
	logic [cvw_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                           m_tlast;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [cvw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cvw_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [cvw_pkg::PIX_W-1:0]          line_mem [KS-1][MAXW];
	logic [cvw_pkg::PIX_W-1:0]          win [KT];
	logic signed [cvw_pkg::COEF_W-1:0]  kernel [KT];
	int unsigned                        col_cnt;
	int unsigned                        row_cnt;
	logic [cvw_pkg::LINE_WIDTH_W-1:0]   width_reg;
	logic [cvw_pkg::FRAME_HEIGHT_W-1:0] height_reg;

	window_sum_t sums_due [$];
	stim_row_t   directed_plan [$];

	int  cycles;
	int  mismatches;
	int  sums_checked;
	int  items_sent;
	int  pixels_sent;
	int  reg_writes;
	bit  calm;
	bit  paused;

	conv2d_valid_window_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit next_window_sum(input pix_item_t it, output window_sum_t res);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		logic [cvw_pkg::PIX_W-1:0] col_px [KS];
		int acc;
		bit hit;
		res = '0;
		if (it.mode == cvw_pkg::MODE_COEF) begin
			if (it.coef_index < KT)
				kernel[it.coef_index] = it.coef_value;
			return 1'b0;
		end
		w = (width_reg > MAXW) ? MAXW : width_reg;
		if (w == 0)
			w = 1;
		h = (height_reg == 0) ? 1 : height_reg;
		c = col_cnt % MAXW;
		for (int i = 0; i < KS - 1; i++)
			col_px[i] = line_mem[KS-2-i][c];
		col_px[KS-1] = it.pixel;
		for (int i = KS - 2; i > 0; i--)
			line_mem[i][c] = line_mem[i-1][c];
		line_mem[0][c] = it.pixel;
		for (int i = 0; i < KS; i++) begin
			for (int j = 0; j + 1 < KS; j++)
				win[i*KS+j] = win[i*KS+j+1];
			win[i*KS+KS-1] = col_px[i];
		end
		hit = (col_cnt >= KS - 1) && (row_cnt >= KS - 1);
		if (hit) begin
			acc = 0;
			for (int k = 0; k < KT; k++)
				acc += int'(win[k]) * int'(kernel[k]);
			res.sum = acc[cvw_pkg::SUM_OUT_W-1:0];
			res.row = cvw_pkg::ROW_OUT_W'(row_cnt - (KS - 1));
			res.col = cvw_pkg::COL_OUT_W'(col_cnt - (KS - 1));
			res.last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
		end
		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & 32'hFFFF);
		end else begin
			col_cnt = (col_cnt + 1) & 32'h3FF;
		end
		return hit;
	endfunction

	function automatic void add_row(logic mode, int idx, int val, int pix, int typed,
			int sum, int row, int col, int last);
		stim_row_t r;
		r.it.mode = mode;
		r.it.coef_index = cvw_pkg::CIDX_W'(idx);
		r.it.coef_value = cvw_pkg::COEF_W'(val);
		r.it.pixel = cvw_pkg::PIX_W'(pix);
		r.typed = (typed != 0);
		r.want.sum = cvw_pkg::SUM_OUT_W'(sum);
		r.want.row = cvw_pkg::ROW_OUT_W'(row);
		r.want.col = cvw_pkg::COL_OUT_W'(col);
		r.want.last = (last != 0);
		directed_plan.push_back(r);
	endfunction

	function automatic pix_item_t rand_pixel();
		pix_item_t it;
		it.mode = cvw_pkg::MODE_PIXEL;
		it.coef_index = cvw_pkg::CIDX_W'($urandom);
		it.coef_value = cvw_pkg::COEF_W'($urandom);
		case ($urandom_range(0, 7))
			0: it.pixel = '0;
			1: it.pixel = '1;
			default: it.pixel = cvw_pkg::PIX_W'($urandom);
		endcase
		return it;
	endfunction

	function automatic pix_item_t rand_coef(input logic [cvw_pkg::CIDX_W-1:0] idx);
		pix_item_t it;
		it.mode = cvw_pkg::MODE_COEF;
		it.coef_index = idx;
		it.pixel = cvw_pkg::PIX_W'($urandom);
		case ($urandom_range(0, 7))
			0: it.coef_value = 16'sh8000;
			1: it.coef_value = 16'sh7FFF;
			default: it.coef_value = cvw_pkg::COEF_W'($urandom);
		endcase
		return it;
	endfunction

	task automatic send_item(input pix_item_t it, input bit typed, input window_sum_t want);
		window_sum_t res;
		bit hit;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= it.mode;
		s_tdata <= cvw_pkg::S_TDATA_W'({it.pixel, it.coef_value, it.coef_index});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		hit = next_window_sum(it, res);
		if (typed) begin
			hit = 1'b1;
			res = want;
		end
		if (hit)
			sums_due.push_back(res);
		items_sent++;
		if (it.mode == cvw_pkg::MODE_PIXEL)
			pixels_sent++;
	endtask

	task automatic src_gap(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 9) == 0)
			src_gap($urandom_range(1, 18));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [cvw_pkg::CFG_IDX_W-1:0] idx,
			input logic [cvw_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == cvw_pkg::REG_LINE_WIDTH)
			width_reg = data[cvw_pkg::LINE_WIDTH_W-1:0];
		else
			height_reg = data;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_kernel();
		for (int k = 0; k < KT; k++) begin
			maybe_gap();
			send_item(rand_coef(cvw_pkg::CIDX_W'(k)), 1'b0, '0);
		end
	endtask

	task automatic push_pixels(input int n, input bit mix);
		logic [cvw_pkg::CIDX_W-1:0] idx;
		for (int p = 0; p < n; p++) begin
			if (mix && !paused && items_sent >= PAUSE_AT) begin
				paused = 1'b1;
				drain_results();
			end
			maybe_gap();
			if (mix && $urandom_range(0, 11) == 0) begin
				idx = ($urandom_range(0, 3) == 0) ? cvw_pkg::CIDX_W'($urandom) :
					cvw_pkg::CIDX_W'($urandom_range(0, KT - 1));
				send_item(rand_coef(idx), 1'b0, '0);
				maybe_gap();
			end
			send_item(rand_pixel(), 1'b0, '0);
		end
	endtask

	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 60);
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
			if (!calm && $urandom_range(0, 2) != 0) begin
				n = $urandom_range(1, 18);
				repeat (n) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_sums
		window_sum_t got;
		window_sum_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.sum = m_tdata[cvw_pkg::SUM_OUT_W-1:0];
			got.row = m_tdata[cvw_pkg::SUM_OUT_W +: cvw_pkg::ROW_OUT_W];
			got.col = m_tdata[cvw_pkg::SUM_OUT_W+cvw_pkg::ROW_OUT_W +: cvw_pkg::COL_OUT_W];
			got.last = m_tlast;
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got sum %0d row %0d col %0d last %0b",
					$time, $signed(got.sum), got.row, got.col, got.last);
				mismatches++;
			end else begin
				want = sums_due.pop_front();
				sums_checked++;
				if (got.sum !== want.sum) begin
					$display("%0t: sum expected %0d, got %0d", $time, $signed(want.sum),
						$signed(got.sum));
					mismatches++;
				end
				if (got.row !== want.row) begin
					$display("%0t: out_row expected %0d, got %0d", $time, want.row, got.row);
					mismatches++;
				end
				if (got.col !== want.col) begin
					$display("%0t: out_col expected %0d, got %0d", $time, want.col, got.col);
					mismatches++;
				end
				if (got.last !== want.last) begin
					$display("%0t: frame_last expected %0b, got %0b", $time, want.last, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int w;
		int h;
		logic [cvw_pkg::CFG_DATA_W-1:0] cfg_word;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		paused = 1'b0;
		width_reg = cvw_pkg::LINE_WIDTH_RST;
		height_reg = cvw_pkg::FRAME_HEIGHT_RST;
		col_cnt = 0;
		row_cnt = 0;
		for (int i = 0; i < KS - 1; i++)
			for (int c = 0; c < MAXW; c++)
				line_mem[i][c] = '0;
		for (int k = 0; k < KT; k++) begin
			win[k] = '0;
			kernel[k] = '0;
		end
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Most negative kernel over a saturated frame gives the lowest sum.
		for (int k = 0; k < KT; k++)
			add_row(cvw_pkg::MODE_COEF, k, -32768, 255, 0, 0, 0, 0, 0);
		add_row(cvw_pkg::MODE_COEF, 15, 32767, 0, 0, 0, 0, 0, 0);
		add_row(cvw_pkg::MODE_COEF, KT, 16'h5A5A, 8'hA5, 0, 0, 0, 0, 0);
		for (int p = 0; p < KT; p++)
			add_row(cvw_pkg::MODE_PIXEL, (p % 2) ? 15 : 0, (p % 2) ? -1 : 32767, 255,
				int'(p == KT - 1), -75202560, 0, 0, 1);
		add_row(cvw_pkg::MODE_COEF, 4, 32767, 0, 0, 0, 0, 0, 0);

		reg_write(cvw_pkg::REG_LINE_WIDTH, cvw_pkg::CFG_DATA_W'(KS));
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, cvw_pkg::CFG_DATA_W'(KS));
		foreach (directed_plan[i]) begin
			maybe_gap();
			send_item(directed_plan[i].it, directed_plan[i].typed, directed_plan[i].want);
		end
		drain_results();

		reg_write(cvw_pkg::REG_LINE_WIDTH, 16'd2);
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, 16'd3);
		push_pixels(6, 1'b0);
		drain_results();
		reg_write(cvw_pkg::REG_LINE_WIDTH, 16'd0);
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, 16'd4);
		push_pixels(4, 1'b0);
		drain_results();
		reg_write(cvw_pkg::REG_LINE_WIDTH, 16'd4);
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, 16'd0);
		push_pixels(4, 1'b0);
		drain_results();

		// Shrink both limits partway through row three; the next pixel ends the frame.
		reg_write(cvw_pkg::REG_LINE_WIDTH, 16'd8);
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, 16'd6);
		push_pixels(29, 1'b0);
		drain_results();
		reg_write(cvw_pkg::REG_LINE_WIDTH, 16'd4);
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, 16'd4);
		push_pixels(1, 1'b0);
		drain_results();

		while (items_sent < RAND_TOTAL) begin
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(KS, 12);
			h = $urandom_range(KS, 8);
			cfg_word = ($urandom_range(0, 3) == 0) ? cvw_pkg::CFG_DATA_W'($urandom) : '0;
			cfg_word[cvw_pkg::LINE_WIDTH_W-1:0] = cvw_pkg::LINE_WIDTH_W'(w);
			drain_results();
			reg_write(cvw_pkg::REG_LINE_WIDTH, cfg_word);
			reg_write(cvw_pkg::REG_FRAME_HEIGHT, cvw_pkg::CFG_DATA_W'(h));
			if ($urandom_range(0, 1) == 0)
				load_kernel();
			repeat ($urandom_range(1, 3))
				push_pixels(w * h, 1'b1);
		end
		drain_results();

		// A width of 24 written with its upper bits set, then a full frame back to back.
		calm = 1'b1;
		reg_write(cvw_pkg::REG_LINE_WIDTH, 16'hF818);
		reg_write(cvw_pkg::REG_FRAME_HEIGHT, 16'd5);
		load_kernel();
		push_pixels(24 * 5, 1'b0);
		drain_results();

		$display("Sent %0d items (%0d pixels) over %0d register writes; compared %0d sums.",
			items_sent, pixels_sent, reg_writes, sums_checked);
		$display("Widths 0 to 40 and heights 0 to 8, with kernel reloads and a limit change mid-frame.");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cvw_pkg.sv
rtl/cvw_fifo.sv
rtl/cvw_front.sv
rtl/cvw_back.sv
rtl/conv2d_valid_window_unit.sv
tb/tb.sv
